/* sv/turn_angle_classifier_macros.svh */
// Assertion macros shared by the checkers of the turn angle classifier.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef TURN_ANGLE_CLASSIFIER_MACROS_SVH
`define TURN_ANGLE_CLASSIFIER_MACROS_SVH

// Condition and consequence in the same cycle.
`define TAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define TAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tac_pkg.sv */
// Shared types, widths and constants of the turn angle classifier.
// No dependencies; every module in the project imports this package.
package tac_pkg;

	localparam int COORD_BITS   = 24;
	localparam int CORDIC_STEPS = 18;

	// Datapath widths.
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int NORM_W  = 32;
	localparam int CX_W    = NORM_W + 4;
	localparam int Z_W     = 27;
	localparam int LIMIT_W = 18;
	localparam int ANGLE_W = 18;

	// Leading-one search is done on groups of bits.
	localparam int GRP     = 8;
	localparam int GRP_LG  = $clog2(GRP);
	localparam int NGRP    = (SUM_W + GRP - 1) / GRP;
	localparam int GIDX_W  = $clog2(NGRP);
	localparam int MPAD_W  = NGRP * GRP;
	localparam int POS_W   = $clog2(MPAD_W);

	// Angle scaling: accumulator in Q24 radians, result in Q16 radians.
	localparam int ROUND_SH   = 8;
	localparam int ROUND_HALF = 1 << (ROUND_SH - 1);

	localparam logic [ANGLE_W-1:0] ANGLE_MAX       = ANGLE_W'(205887);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(11438);
	localparam logic signed [Z_W-1:0] HALF_PI_Q24  = Z_W'(26353589);

	// One input word: the three corner points.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] first_x;
		logic signed [COORD_BITS-1:0] first_y;
		logic signed [COORD_BITS-1:0] middle_x;
		logic signed [COORD_BITS-1:0] middle_y;
		logic signed [COORD_BITS-1:0] last_x;
		logic signed [COORD_BITS-1:0] last_y;
	} tac_points_t;

	// One result word.
	typedef struct packed {
		logic [ANGLE_W-1:0] turn_angle;
		logic               small_turn;
		logic               turns_positive;
		logic               degenerate;
	} tac_turn_t;

	// Control bits that travel with each word down the pipeline.
	typedef struct packed {
		logic valid;
		logic degenerate;
		logic cross_pos;
	} tac_tag_t;

	// atan(2^-i) in Q24 radians, rounded to nearest.
	function automatic logic signed [Z_W-1:0] atan_q24(input int i);
		case (i)
			0:       atan_q24 = Z_W'(13176795);
			1:       atan_q24 = Z_W'(7778716);
			2:       atan_q24 = Z_W'(4110060);
			3:       atan_q24 = Z_W'(2086331);
			4:       atan_q24 = Z_W'(1047214);
			5:       atan_q24 = Z_W'(524117);
			6:       atan_q24 = Z_W'(262123);
			7:       atan_q24 = Z_W'(131069);
			8:       atan_q24 = Z_W'(65536);
			9:       atan_q24 = Z_W'(32768);
			10:      atan_q24 = Z_W'(16384);
			11:      atan_q24 = Z_W'(8192);
			12:      atan_q24 = Z_W'(4096);
			13:      atan_q24 = Z_W'(2048);
			14:      atan_q24 = Z_W'(1024);
			15:      atan_q24 = Z_W'(512);
			16:      atan_q24 = Z_W'(256);
			17:      atan_q24 = Z_W'(128);
			18:      atan_q24 = Z_W'(64);
			19:      atan_q24 = Z_W'(32);
			20:      atan_q24 = Z_W'(16);
			21:      atan_q24 = Z_W'(8);
			22:      atan_q24 = Z_W'(4);
			23:      atan_q24 = Z_W'(2);
			default: atan_q24 = '0;
		endcase
	endfunction

endpackage

/* sv/tac_norm.sv */
// Magnitudes, leading-one search and normalizing shift of dot and cross.
// Stages s4 to s9 of the pipeline; depends on tac_pkg.
module tac_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  tac_pkg::tac_tag_t                   tag_i,
	input  logic signed [tac_pkg::SUM_W-1:0]    dot_i,
	input  logic signed [tac_pkg::SUM_W-1:0]    cross_i,
	output tac_pkg::tac_tag_t                   tag_o,
	output logic signed [tac_pkg::CX_W-1:0]     x_o,
	output logic signed [tac_pkg::CX_W-1:0]     y_o,
	output logic signed [tac_pkg::Z_W-1:0]      z_o
);
	import tac_pkg::*;

	tac_tag_t             tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;
	logic [SUM_W-1:0]     dm_s4, ac_s4, dm_s5, ac_s5, dm_s6, ac_s6, dm_s7, ac_s7;
	logic                 dneg_s4, dneg_s5, dneg_s6, dneg_s7, dneg_s8;
	logic [SUM_W-1:0]     m_s5;
	logic [MPAD_W-1:0]    m_pad;
	logic [MPAD_W-1:0]    m_s6;
	logic [NGRP-1:0]      grp_nz;
	logic [NGRP-1:0]      grp_s6;
	logic [GIDX_W-1:0]    lead_g;
	logic [GRP-1:0]       lead_grp;
	logic [GRP_LG-1:0]    lead_b;
	logic [POS_W-1:0]     pos;
	logic [POS_W-1:0]     pos_s7;
	logic [POS_W-1:0]     rsh, lsh;
	logic [NORM_W-1:0]    dmn, acn;
	logic [NORM_W-1:0]    dmn_s8, acn_s8;
	logic                 rot;
	logic signed [CX_W-1:0] x_s9, y_s9;
	logic signed [Z_W-1:0]  z_s9;

	// Tags advance with the words; cross sign is known from s4 on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
			tag_s9 <= '0;
		end else if (en) begin
			tag_s4 <= '{valid: tag_i.valid, degenerate: tag_i.degenerate,
				cross_pos: (!cross_i[SUM_W-1] && (cross_i != '0))};
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			tag_s9 <= tag_s8;
		end
	end

	// s4: magnitudes of dot and cross.
	always_ff @(posedge clk) begin
		if (en) begin
			dm_s4   <= dot_i[SUM_W-1] ? $unsigned(-dot_i) : $unsigned(dot_i);
			ac_s4   <= cross_i[SUM_W-1] ? $unsigned(-cross_i) : $unsigned(cross_i);
			dneg_s4 <= dot_i[SUM_W-1];
		end
	end

	// s5: the larger magnitude sets the common shift.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s5    <= (dm_s4 > ac_s4) ? dm_s4 : ac_s4;
			dm_s5   <= dm_s4;
			ac_s5   <= ac_s4;
			dneg_s5 <= dneg_s4;
		end
	end

	// s6: nonzero flag for each group of bits.
	assign m_pad = MPAD_W'(m_s5);

	always_comb begin
		for (int k = 0; k < NGRP; k++)
			grp_nz[k] = |m_pad[k*GRP +: GRP];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s6  <= grp_nz;
			m_s6    <= m_pad;
			dm_s6   <= dm_s5;
			ac_s6   <= ac_s5;
			dneg_s6 <= dneg_s5;
		end
	end

	// s7: highest nonzero group, then the leading bit inside it.
	always_comb begin
		lead_g = '0;
		for (int k = 0; k < NGRP; k++)
			if (grp_s6[k])
				lead_g = GIDX_W'(k);
		lead_grp = m_s6[lead_g*GRP +: GRP];
		lead_b = '0;
		for (int k = 0; k < GRP; k++)
			if (lead_grp[k])
				lead_b = GRP_LG'(k);
		pos = (POS_W'(lead_g) << GRP_LG) | POS_W'(lead_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s7  <= pos;
			dm_s7   <= dm_s6;
			ac_s7   <= ac_s6;
			dneg_s7 <= dneg_s6;
		end
	end

	// s8: move the leading one to bit NORM_W-1; right shifts truncate.
	always_comb begin
		rsh = pos_s7 - POS_W'(NORM_W - 1);
		lsh = POS_W'(NORM_W - 1) - pos_s7;
		if (pos_s7 >= POS_W'(NORM_W - 1)) begin
			dmn = NORM_W'(dm_s7 >> rsh);
			acn = NORM_W'(ac_s7 >> rsh);
		end else begin
			dmn = NORM_W'(dm_s7 << lsh);
			acn = NORM_W'(ac_s7 << lsh);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmn_s8  <= dmn;
			acn_s8  <= acn;
			dneg_s8 <= dneg_s7;
		end
	end

	// s9: a negative dot is turned by -90 degrees so the vector lies in the
	// right half plane. A dot that truncated to zero needs no turn.
	assign rot = dneg_s8 && (dmn_s8 != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s9 <= CX_W'(rot ? acn_s8 : dmn_s8);
			y_s9 <= CX_W'(rot ? dmn_s8 : acn_s8);
			z_s9 <= rot ? HALF_PI_Q24 : '0;
		end
	end

	assign tag_o = tag_s9;
	assign x_o   = x_s9;
	assign y_o   = y_s9;
	assign z_o   = z_s9;

endmodule

/* sv/tac_cordic.sv */
// Vectoring CORDIC, one register stage per iteration.
// Drives the y component to zero and accumulates the angle; depends on tac_pkg.
module tac_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  tac_pkg::tac_tag_t                 tag_i,
	input  logic signed [tac_pkg::CX_W-1:0]   x_i,
	input  logic signed [tac_pkg::CX_W-1:0]   y_i,
	input  logic signed [tac_pkg::Z_W-1:0]    z_i,
	output tac_pkg::tac_tag_t                 tag_o,
	output logic signed [tac_pkg::Z_W-1:0]    z_o
);
	import tac_pkg::*;

	// The last iteration needs only the angle, so x and y stop one short.
	logic signed [CX_W-1:0] x_s [CORDIC_STEPS-1];
	logic signed [CX_W-1:0] y_s [CORDIC_STEPS-1];
	logic signed [Z_W-1:0]  z_s [CORDIC_STEPS];
	tac_tag_t               tag_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic signed [CX_W-1:0] xa, ya;
		logic signed [Z_W-1:0]  za;
		tac_tag_t               ta;
		logic                   y_nonneg;

		if (i == 0) begin : g_first
			assign xa = x_i;
			assign ya = y_i;
			assign za = z_i;
			assign ta = tag_i;
		end else begin : g_next
			assign xa = x_s[i-1];
			assign ya = y_s[i-1];
			assign za = z_s[i-1];
			assign ta = tag_s[i-1];
		end

		assign y_nonneg = !ya[CX_W-1];

		// Valid and flags move with the word.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (en) begin
				tag_s[i] <= ta;
			end
		end

		// Angle accumulator.
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i] <= y_nonneg ? za + atan_q24(i) : za - atan_q24(i);
			end
		end

		// Micro-rotation toward the x axis; shifts round toward minus infinity.
		if (i < CORDIC_STEPS - 1) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i] <= y_nonneg ? xa + (ya >>> i) : xa - (ya >>> i);
					y_s[i] <= y_nonneg ? ya - (xa >>> i) : ya + (xa >>> i);
				end
			end
		end
	end

	assign tag_o = tag_s[CORDIC_STEPS-1];
	assign z_o   = z_s[CORDIC_STEPS-1];

endmodule

/* sv/turn_angle_classifier.sv */
// Top level of the turn angle classifier: differences, products, output stage.
// Depends on tac_pkg, tac_norm and tac_cordic.
//
// Takes one word of three path points per cycle while the output is not
// stalled and returns the deviation angle between the incoming and outgoing
// segments in radians times 65536, a small-turn flag, a positive-turn flag
// and a degenerate flag for a zero-length segment. Every stage is a register
// with its own valid bit, so a new word is taken in every unstalled cycle; the
// depth is set by one stage each for the differences, the four products and
// the dot/cross sums, six for the normalizing shift, one per CORDIC iteration
// and one for rounding. When a result is held on the output the whole
// pipeline stops and pts_ready drops. small_turn_limit is written through
// limit_we/limit_data and is compared at the output stage.
module turn_angle_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pts_valid,
	output logic                             pts_ready,
	input  tac_pkg::tac_points_t             pts,
	output logic                             turn_valid,
	input  logic                             turn_ready,
	output tac_pkg::tac_turn_t               turn,
	input  logic                             limit_we,
	input  logic [tac_pkg::LIMIT_W-1:0]      limit_data
);
	import tac_pkg::*;

	logic                    en;
	logic [LIMIT_W-1:0]      limit_q;
	logic signed [DIFF_W-1:0] ix, iy, ox, oy;
	logic signed [DIFF_W-1:0] ix_s1, iy_s1, ox_s1, oy_s1;
	tac_tag_t                tag_s1, tag_s2, tag_s3;
	logic signed [PROD_W-1:0] pxx_s2, pyy_s2, pc1_s2, pc2_s2;
	logic signed [SUM_W-1:0]  dot_s3, cross_s3;
	tac_tag_t                ntag;
	logic signed [CX_W-1:0]  nx, ny;
	logic signed [Z_W-1:0]   nz;
	tac_tag_t                ctag;
	logic signed [Z_W-1:0]   cz;
	logic [Z_W-1:0]          zpos, zrnd;
	logic [Z_W-ROUND_SH-1:0] ang_full;
	logic [ANGLE_W-1:0]      ang;
	logic                    turn_valid_q;
	tac_turn_t               turn_q;

	// The pipeline advances unless a result is waiting on a stalled output.
	assign en        = !turn_valid_q || turn_ready;
	assign pts_ready = en;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_data;
		end
	end

	// Segment vectors.
	assign ix = DIFF_W'(pts.middle_x) - DIFF_W'(pts.first_x);
	assign iy = DIFF_W'(pts.middle_y) - DIFF_W'(pts.first_y);
	assign ox = DIFF_W'(pts.last_x) - DIFF_W'(pts.middle_x);
	assign oy = DIFF_W'(pts.last_y) - DIFF_W'(pts.middle_y);

	// Valid and flags for s1 to s3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= '{valid: pts_valid,
				degenerate: ((ix == '0) && (iy == '0)) || ((ox == '0) && (oy == '0)),
				cross_pos: 1'b0};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// s1 differences, s2 products, s3 dot and cross sums.
	always_ff @(posedge clk) begin
		if (en) begin
			ix_s1    <= ix;
			iy_s1    <= iy;
			ox_s1    <= ox;
			oy_s1    <= oy;
			pxx_s2   <= PROD_W'(ix_s1) * PROD_W'(ox_s1);
			pyy_s2   <= PROD_W'(iy_s1) * PROD_W'(oy_s1);
			pc1_s2   <= PROD_W'(ox_s1) * PROD_W'(iy_s1);
			pc2_s2   <= PROD_W'(oy_s1) * PROD_W'(ix_s1);
			dot_s3   <= SUM_W'(pxx_s2) + SUM_W'(pyy_s2);
			cross_s3 <= SUM_W'(pc1_s2) - SUM_W'(pc2_s2);
		end
	end

	tac_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_i   (tag_s3),
		.dot_i   (dot_s3),
		.cross_i (cross_s3),
		.tag_o   (ntag),
		.x_o     (nx),
		.y_o     (ny),
		.z_o     (nz)
	);

	tac_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (ntag),
		.x_i    (nx),
		.y_i    (ny),
		.z_i    (nz),
		.tag_o  (ctag),
		.z_o    (cz)
	);

	// Clamp at zero, round Q24 to Q16 half up, clamp at the top.
	always_comb begin
		zpos     = cz[Z_W-1] ? '0 : $unsigned(cz);
		zrnd     = zpos + Z_W'(ROUND_HALF);
		ang_full = zrnd[Z_W-1:ROUND_SH];
		ang      = (ang_full > (Z_W-ROUND_SH)'(ANGLE_MAX)) ? ANGLE_MAX : ANGLE_W'(ang_full);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_valid_q <= 1'b0;
		end else if (en) begin
			turn_valid_q <= ctag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			turn_q.turn_angle     <= ctag.degenerate ? '0 : ang;
			turn_q.small_turn     <= !ctag.degenerate && (ang < limit_q);
			turn_q.turns_positive <= !ctag.degenerate && ctag.cross_pos;
			turn_q.degenerate     <= ctag.degenerate;
		end
	end

	assign turn_valid = turn_valid_q;
	assign turn       = turn_q;

endmodule

/* sv/tac_checker.sv */
// Port-level checks of the turn angle classifier, bound to the top level.
// Depends on tac_pkg and turn_angle_classifier_macros.svh.
`include "turn_angle_classifier_macros.svh"

module tac_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pts_ready,
	input logic                 turn_valid,
	input logic                 turn_ready,
	input tac_pkg::tac_turn_t   turn
);
	import tac_pkg::*;

	// A degenerate word carries no angle and no flags.
	`TAC_ASSERT_NOW(a_degen_clear, turn_valid && turn.degenerate, (turn.turn_angle == '0) && !turn.small_turn && !turn.turns_positive, "degenerate word with angle or flags set")

	// The angle never exceeds pi in Q16.
	`TAC_ASSERT_NOW(a_angle_range, turn_valid, turn.turn_angle <= ANGLE_MAX, "turn angle above pi")

	// With the output empty the pipeline must take words.
	`TAC_ASSERT_NOW(a_open_when_empty, !turn_valid, pts_ready, "input stalled while output is empty")

	// A stalled result holds.
	`TAC_ASSERT_NEXT(a_hold, turn_valid && !turn_ready, turn_valid && $stable(turn), "stalled result changed")

endmodule

bind turn_angle_classifier tac_checker u_tac_checker (.*);

/* tb/tac_turn_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the turn angle classifier. It predicts each result word from
// the point word that was taken and compares it with what the block returns.
// Depends on tac_pkg for the word types, widths and the limit's reset value.
module tac_turn_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pts_valid,
	input  logic                          pts_ready,
	input  tac_pkg::tac_points_t          pts,
	input  logic                          turn_valid,
	input  logic                          turn_ready,
	input  tac_pkg::tac_turn_t            turn,
	input  logic                          limit_we,
	input  logic [tac_pkg::LIMIT_W-1:0]   limit_data,
	output int                            mismatches,
	output int                            pending
);
	import tac_pkg::*;

	localparam int     ATAN_LEN     = 24;
	localparam int     STEPS        = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam longint QUARTER_Q24  = 64'sd26353589;
	localparam longint ANGLE_CEIL   = 64'sd205887;
	localparam longint NORM_HIGH    = 64'sd4294967296;
	localparam longint NORM_LOW     = 64'sd2147483648;

	// Rotation angles atan(2^-i) in radians times 2^24, rounded to nearest.
	longint atan_step [0:ATAN_LEN-1] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	tac_turn_t          expected_turns [$];
	logic [LIMIT_W-1:0] limit_copy;
	int                 mismatch_count = 0;
	int                 pending_count = 0;

	assign mismatches = mismatch_count;
	assign pending    = pending_count;

	// Unsigned angle of the vector (dot, |cross|) by vectoring rotations,
	// in radians times 65536.
	function automatic logic [ANGLE_W-1:0] cordic_angle(input longint dot,
			input longint cross_mag);
		longint dm, cm, m, x, y, z, nx, ny;
		dm = (dot < 0) ? -dot : dot;
		cm = cross_mag;
		m  = (dm > cm) ? dm : cm;
		if (m == 0) begin
			return '0;
		end
		// One common shift brings the larger magnitude into [2^31, 2^32).
		while (m >= NORM_HIGH) begin
			m = m >>> 1;
			dm = dm >>> 1;
			cm = cm >>> 1;
		end
		while (m < NORM_LOW) begin
			m = m <<< 1;
			dm = dm <<< 1;
			cm = cm <<< 1;
		end
		x = (dot < 0) ? -dm : dm;
		y = cm;
		z = 0;
		// A vector in the left half plane is turned back by a quarter turn first.
		if (x < 0) begin
			nx = y;
			y = -x;
			x = nx;
			z = QUARTER_Q24;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + atan_step[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - atan_step[i];
			end
			x = nx;
			y = ny;
		end
		if (z < 0) begin
			z = 0;
		end
		z = (z + 128) >>> 8;
		if (z > ANGLE_CEIL) begin
			z = ANGLE_CEIL;
		end
		return z[ANGLE_W-1:0];
	endfunction

	// Expected result word for one corner under the given small-turn limit.
	function automatic tac_turn_t predict_turn(input tac_points_t p,
			input logic [LIMIT_W-1:0] lim);
		longint ix, iy, ox, oy, dot, cross_val;
		tac_turn_t r;
		ix = longint'($signed(p.middle_x)) - longint'($signed(p.first_x));
		iy = longint'($signed(p.middle_y)) - longint'($signed(p.first_y));
		ox = longint'($signed(p.last_x)) - longint'($signed(p.middle_x));
		oy = longint'($signed(p.last_y)) - longint'($signed(p.middle_y));
		r = '0;
		// A zero-length segment gives only the degenerate flag.
		if ((ix == 0 && iy == 0) || (ox == 0 && oy == 0)) begin
			r.degenerate = 1'b1;
			return r;
		end
		dot = ix * ox + iy * oy;
		cross_val = ox * iy - oy * ix;
		r.turn_angle = cordic_angle(dot, (cross_val < 0) ? -cross_val : cross_val);
		r.small_turn = (r.turn_angle < lim);
		r.turns_positive = (cross_val > 0);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t turn word mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Track the limit, queue a prediction per taken word, and check each
	// returned word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		tac_turn_t want;
		if (!arst_n) begin
			limit_copy = LIMIT_RESET;
			expected_turns.delete();
		end else begin
			if (turn_valid && turn_ready) begin
				if (expected_turns.size() == 0) begin
					report_mismatch($sformatf("word with nothing expected, angle %0d",
						turn.turn_angle));
				end else begin
					want = expected_turns.pop_front();
					if (turn.turn_angle !== want.turn_angle)
						report_mismatch($sformatf("turn_angle got %0d expected %0d",
							turn.turn_angle, want.turn_angle));
					if (turn.small_turn !== want.small_turn)
						report_mismatch($sformatf("small_turn got %b expected %b",
							turn.small_turn, want.small_turn));
					if (turn.turns_positive !== want.turns_positive)
						report_mismatch($sformatf("turns_positive got %b expected %b",
							turn.turns_positive, want.turns_positive));
					if (turn.degenerate !== want.degenerate)
						report_mismatch($sformatf("degenerate got %b expected %b",
							turn.degenerate, want.degenerate));
				end
			end
			if (pts_valid && pts_ready) begin
				expected_turns = {expected_turns, predict_turn(pts, limit_copy)};
			end
			if (limit_we) begin
				limit_copy = limit_data;
			end
		end
		pending_count = expected_turns.size();
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the turn angle classifier: clock, reset, point words,
// limit writes, watchdog and verdict. Depends on tac_pkg, the block and tac_turn_checker.
module tb_top;
	import tac_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_WORDS  = 800;
	localparam int PHASES        = 6;
	localparam int IDLE_PCT      = 20;
	localparam int SETTLE_CYCLES = 32;
	localparam int QUIET_LIMIT   = 2000;
	localparam int CMAX          = 8388607;
	localparam int CMIN          = -8388608;
	localparam logic [LIMIT_W-1:0] LIMIT_FULL = '1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               pts_valid;
	logic               pts_ready;
	tac_points_t        pts;
	logic               turn_valid;
	logic               turn_ready = 1'b0;
	tac_turn_t          turn;
	logic               limit_we;
	logic [LIMIT_W-1:0] limit_data;
	int                 mismatches;
	int                 pending;
	bit                 tx_steady = 1'b0;
	bit                 rx_steady = 1'b0;
	int                 quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	turn_angle_classifier u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pts_valid  (pts_valid),
		.pts_ready  (pts_ready),
		.pts        (pts),
		.turn_valid (turn_valid),
		.turn_ready (turn_ready),
		.turn       (turn),
		.limit_we   (limit_we),
		.limit_data (limit_data)
	);

	tac_turn_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pts_valid  (pts_valid),
		.pts_ready  (pts_ready),
		.pts        (pts),
		.turn_valid (turn_valid),
		.turn_ready (turn_ready),
		.turn       (turn),
		.limit_we   (limit_we),
		.limit_data (limit_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// The receiver stalls at random, IDLE_PCT percent of the time, unless held steady.
	always @(negedge clk) begin
		turn_ready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Watchdog: too long without any word moving ends the run.
	always @(posedge clk) begin
		if (!arst_n || (pts_valid && pts_ready) || (turn_valid && turn_ready) || limit_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL turn_angle_classifier");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic tac_points_t corner(input int ax, input int ay, input int bx,
			input int by, input int cx, input int cy);
		tac_points_t w;
		w.first_x  = COORD_BITS'(ax);
		w.first_y  = COORD_BITS'(ay);
		w.middle_x = COORD_BITS'(bx);
		w.middle_y = COORD_BITS'(by);
		w.last_x   = COORD_BITS'(cx);
		w.last_y   = COORD_BITS'(cy);
		return w;
	endfunction

	function automatic int span_rand(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Random corner: mostly free coordinates, plus tight clusters, near-straight
	// paths with bends of every size, zero-length segments and doubling back.
	function automatic tac_points_t random_corner();
		int kind, ax, ay, bx, by, dx, dy, nx, ny, bend;
		tac_points_t w;
		kind = $urandom_range(0, 99);
		w = corner($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (kind < 45) begin
			return w;
		end else if (kind < 65) begin
			ax = span_rand(1 << 22);
			ay = span_rand(1 << 22);
			bx = ax + span_rand(8);
			by = ay + span_rand(8);
			w = corner(ax, ay, bx, by, bx + span_rand(8), by + span_rand(8));
		end else if (kind < 82) begin
			ax = span_rand(1 << 21);
			ay = span_rand(1 << 21);
			dx = span_rand(1 << 20);
			dy = span_rand(1 << 20);
			bend = $urandom_range(0, 19);
			nx = span_rand(1 << bend);
			ny = span_rand(1 << bend);
			w = corner(ax, ay, ax + dx, ay + dy, ax + 2 * dx + nx, ay + 2 * dy + ny);
		end else if (kind < 92) begin
			if ($urandom_range(0, 1) == 1) begin
				w.middle_x = w.first_x;
				w.middle_y = w.first_y;
			end else begin
				w.last_x = w.middle_x;
				w.last_y = w.middle_y;
			end
		end else begin
			w.last_x = w.first_x + COORD_BITS'(span_rand(64));
			w.last_y = w.first_y + COORD_BITS'(span_rand(64));
		end
		return w;
	endfunction

	// Present one point word, with random idle cycles ahead of it, and hold
	// it until the block takes it.
	task automatic send_corner(input tac_points_t word);
		@(negedge clk);
		while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
			pts_valid = 1'b0;
			@(negedge clk);
		end
		pts = word;
		pts_valid = 1'b1;
		do @(posedge clk); while (!pts_ready);
	endtask

	// The limit is only written once every result is back and the pipeline is empty.
	task automatic set_small_turn_limit(input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		pts_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		limit_we = 1'b1;
		limit_data = value;
		@(negedge clk);
		limit_we = 1'b0;
	endtask

	initial begin
		logic [LIMIT_W-1:0] phase_limit;
		arst_n = 1'b0;
		pts_valid = 1'b0;
		pts = '0;
		limit_we = 1'b0;
		limit_data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed corners under the reset limit of ten degrees.
		send_corner(corner(0, 0, 0, 0, 0, 0));
		send_corner(corner(5, -3, 5, -3, 9, 1));
		send_corner(corner(-7, 2, 4, 4, 4, 4));
		send_corner(corner(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
		send_corner(corner(0, 0, 1, 0, 2, 0));
		send_corner(corner(0, 0, 1, 0, 1, 1));
		send_corner(corner(0, 0, 1, 0, 1, -1));
		send_corner(corner(0, 0, 1, 0, 0, 0));
		send_corner(corner(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN));
		send_corner(corner(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX));
		send_corner(corner(CMIN, 0, 0, 0, CMAX, 0));
		send_corner(corner(CMIN, CMIN, CMAX, CMIN, CMAX, CMAX));
		send_corner(corner(0, 0, 1000, 0, 2000, 174));
		send_corner(corner(0, 0, 1000, 0, 2000, 177));
		send_corner(corner(0, 0, 1, 1, 2, 1));
		send_corner(corner(0, 0, -1, 0, -2, 1));
		send_corner(corner(0, 0, 3, 0, 1, 1));
		send_corner(corner(0, 0, 3, 0, 1, -1));
		send_corner(corner(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX - 1));
		send_corner(corner(0, 0, CMAX, 0, CMAX, 1));
		send_corner(corner(-1, -1, 0, 0, 1, 1));
		send_corner(corner(0, 0, 0, 1, 1, 1));

		// Random corners over several limits, the extremes among them.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       phase_limit = '0;
				1:       phase_limit = ANGLE_MAX;
				2:       phase_limit = LIMIT_FULL;
				3:       phase_limit = LIMIT_W'($urandom_range(0, 205887));
				4:       phase_limit = LIMIT_W'($urandom_range(1, 23000));
				default: phase_limit = LIMIT_RESET;
			endcase
			set_small_turn_limit(phase_limit);
			// One whole phase runs with neither side idling.
			tx_steady = (p == 2);
			rx_steady = (p == 2);
			for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
				send_corner(random_corner());
			end
		end

		@(negedge clk);
		pts_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("PASS turn_angle_classifier");
		end else begin
			$display("FAIL turn_angle_classifier");
		end
		$finish;
	end

endmodule
